[rtl/sha_pkg.sv]
// package: types, constants and functions shared by the sha-256 digest block
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned VbW = 6;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned LenSlotWord = 448 / 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned DigestWords = 8;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [5:0]  valid_bits;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // word source selects for the datapath
  typedef enum logic [2:0] {
    SRC_MSG   = 3'b000,
    SRC_PAD   = 3'b001,
    SRC_ZERO  = 3'b010,
    SRC_LENHI = 3'b011,
    SRC_LENLO = 3'b100
  } src_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       push;      // write a word into the block buffer
    src_e       src;
    logic       add_len;   // add item length to the bit count
    logic       init_vars; // load working vars from chain hash
    logic       round;     // run one compression round
    logic [5:0] round_idx;
    logic       feed_fwd;  // add working vars into chain hash
    logic       clear;     // restore initial hash and length
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [3:0] words;     // words held in current block
  } sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  localparam logic [31:0] K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

[rtl/sha256_message_digest.sv]
// sha-256 digest of a word-streamed message, eight digest words out
// a message word is taken only while idle; the sixteenth word of a block starts 64 rounds
// plus one feed-forward step, and no word is taken until they are done
// the last word costs padding pushes (up to 18) and one or two blocks, then
// eight digest transactions; reset (async, active low) restores the initial hash
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_digest (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sha_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sha_pkg::out_item_t     out_data_o
);

  sha_pkg::ctl_t ctl;
  sha_pkg::sts_t sts;
  logic [2:0]    rd_idx;
  logic [31:0]   hash;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_data_i),
    .out_valid_o, .out_ready_i, .ctl_o(ctl), .sts_i(sts), .rd_idx_o(rd_idx)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .item_i(in_data_i), .rd_idx_i(rd_idx),
    .sts_o(sts), .hash_o(hash)
  );

  // digest transaction fields
  assign out_data_o.digest_word = hash;
  assign out_data_o.digest_index = rd_idx;
  assign out_data_o.digest_last = (rd_idx == 3'd7);

endmodule
`default_nettype wire

[rtl/sha_datapath.sv]
// datapath: block buffer, schedule window, working vars, chain hash, length
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sha_pkg::ctl_t    ctl_i,
  input  wire sha_pkg::in_item_t item_i,
  input  wire logic [2:0]       rd_idx_i,
  output sha_pkg::sts_t         sts_o,
  output logic [31:0]           hash_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] len_q, len_d;
  logic [3:0]  cnt_q;
  logic [5:0]  vb;
  logic [31:0] keep, msg_w, push_w;
  logic [31:0] wt, wnew, s1, s0, chv, mjv, t1, t2;
  logic [3:0]  ti;

  // saturate valid bit count on the last word
  always_comb begin
    vb = item_i.last_word ? ((item_i.valid_bits > 6'd32) ? 6'd32 : item_i.valid_bits)
                          : 6'd32;
    keep = (vb == 6'd0) ? 32'd0 : (32'hffffffff << (6'd32 - vb));
    msg_w = (vb == 6'd32) ? item_i.msg_word
                          : ((item_i.msg_word & keep) | (32'h80000000 >> vb));
    len_d = len_q + {58'd0, vb};
  end

  // select the word to push
  always_comb begin
    case (ctl_i.src)
      sha_pkg::SRC_MSG:   push_w = msg_w;
      sha_pkg::SRC_PAD:   push_w = 32'h80000000;
      sha_pkg::SRC_LENHI: push_w = len_q[63:32];
      sha_pkg::SRC_LENLO: push_w = len_q[31:0];
      default:            push_w = 32'd0;
    endcase
  end

  // one round: schedule expansion and compression
  always_comb begin
    ti = ctl_i.round_idx[3:0];
    wnew = (sha_pkg::rotr(w_q[ti - 4'd2], 17) ^ sha_pkg::rotr(w_q[ti - 4'd2], 19)
            ^ (w_q[ti - 4'd2] >> 10)) + w_q[ti - 4'd7]
           + (sha_pkg::rotr(w_q[ti - 4'd15], 7) ^ sha_pkg::rotr(w_q[ti - 4'd15], 18)
              ^ (w_q[ti - 4'd15] >> 3)) + w_q[ti];
    wt = (ctl_i.round_idx >= 6'd16) ? wnew : w_q[ti];
    s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
    s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
    chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mjv = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + s1 + chv + sha_pkg::K[ctl_i.round_idx] + wt;
    t2 = s0 + mjv;
  end

  // schedule window and block buffer
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) w_q[cnt_q] <= push_w;
    else if (ctl_i.round) w_q[ti] <= wt;
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctl_i.init_vars) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (ctl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // chain hash, length and word count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_hash(3'(i));
      len_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.clear) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_hash(3'(i));
      len_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctl_i.feed_fwd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (ctl_i.add_len) len_q <= len_d;
      if (ctl_i.push) cnt_q <= cnt_q + 4'd1;
    end
  end

  assign sts_o.words = cnt_q;
  assign hash_o = h_q[rd_idx_i];

endmodule
`default_nettype wire

[rtl/sha_ctrl.sv]
// controller: handshakes, padding sequence, round counting, digest output
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sha_pkg::in_item_t in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sha_pkg::ctl_t         ctl_o,
  input  wire sha_pkg::sts_t    sts_i,
  output logic [2:0]            rd_idx_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_FILL  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FEED  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic       fin_q, fin_d;   // final block of a message
  logic       pad_q, pad_d;   // pad word still owed
  logic       lo_q, lo_d;     // low length word next
  logic [2:0] idx_q, idx_d;
  logic       acc, full;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign rd_idx_o = idx_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    fin_d = fin_q;
    pad_d = pad_q;
    lo_d = lo_q;
    idx_d = idx_q;
    ctl_o = '0;
    ctl_o.src = sha_pkg::SRC_ZERO;
    ctl_o.round_idx = rnd_q;
    full = (sts_i.words == 4'd15);
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          ctl_o.push = 1'b1;
          ctl_o.src = sha_pkg::SRC_MSG;
          ctl_o.add_len = 1'b1;
          fin_d = in_item_i.last_word;
          pad_d = in_item_i.last_word && (in_item_i.valid_bits >= 6'd32);
          lo_d = 1'b0;
          if (full) begin
            ctl_o.init_vars = 1'b1;
            rnd_d = '0;
            state_d = ST_ROUND;
          end else if (in_item_i.last_word) begin
            state_d = pad_d ? ST_PAD : ST_FILL;
          end
        end
      end
      ST_PAD, ST_FILL, ST_LEN: begin
        ctl_o.push = 1'b1;
        if (pad_q) begin
          ctl_o.src = sha_pkg::SRC_PAD;
          pad_d = 1'b0;
        end else if (sts_i.words == 4'(sha_pkg::LenSlotWord) && !lo_q) begin
          ctl_o.src = sha_pkg::SRC_LENHI;
          lo_d = 1'b1;
        end else if (lo_q) begin
          ctl_o.src = sha_pkg::SRC_LENLO;
        end
        if (full) begin
          ctl_o.init_vars = 1'b1;
          rnd_d = '0;
          state_d = ST_ROUND;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_ROUND: begin
        ctl_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(sha_pkg::Rounds - 1)) state_d = ST_FEED;
      end
      ST_FEED: begin
        ctl_o.feed_fwd = 1'b1;
        idx_d = '0;
        // final block ends only after the low length word went in
        if (fin_q && lo_q) state_d = ST_OUT;
        else if (fin_q) state_d = ST_FILL;
        else state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctl_o.clear = 1'b1;
            fin_d = 1'b0;
            lo_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q <= '0;
      fin_q <= 1'b0;
      pad_q <= 1'b0;
      lo_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      fin_q <= fin_d;
      pad_q <= pad_d;
      lo_q <= lo_d;
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire
